// ----- rtl/stf_pkg.sv -----
// Shared types and constants for the scanline triangle filler.
package stf_pkg;

  localparam int FIELD_W = 6;

  typedef struct packed {
    logic [FIELD_W-1:0] vertex_a_x;
    logic [FIELD_W-1:0] vertex_a_y;
    logic [FIELD_W-1:0] vertex_b_x;
    logic [FIELD_W-1:0] vertex_b_y;
    logic [FIELD_W-1:0] vertex_c_x;
    logic [FIELD_W-1:0] vertex_c_y;
  } vertices_t;

  typedef struct packed {
    logic [FIELD_W-1:0] row;
    logic [FIELD_W-1:0] span_from_x;
    logic [FIELD_W-1:0] span_to_x;
    logic               last_span;
  } span_t;

  // Which edge the shared multiply/divide unit evaluates.
  typedef enum logic [1:0] {
    OP_XS   = 2'd0,
    OP_FROM = 2'd1,
    OP_TO   = 2'd2
  } op_t;

  typedef struct packed {
    logic load_tri;
    logic mul_go;
    logic div_step;
    logic store_res;
    logic load_out;
    logic next_row;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic flat_all;
    logic div_last;
    logic last_row;
    logic out_free;
  } sts_t;

endpackage

// ----- rtl/scanline_triangle_fill.sv -----
// Top level of the scanline triangle filler.
//
//   channel    dir  payload      handshake
//   vertices   in   vertices_t   vertices_valid / vertices_stall
//   span       out  span_t       span_valid / span_stall
//
// One triangle at a time; its spans leave in row order, last one flagged.
// Each edge value is computed on the shared restoring divider; a row needs two,
// plus one split point per triangle. A triangle with all y equal gives one span
// straight away, with no divider pass.
// Reset (rst, synchronous) empties the output register and idles the sequencer.
// A stalled span holds the output register; the next triangle may be taken
// while the final span of the previous one is still waiting.
module scanline_triangle_fill import stf_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      vertices_valid,
  output logic      vertices_stall,
  input  vertices_t vertices,
  output logic      span_valid,
  input  logic      span_stall,
  output span_t     span
);

  cmd_t cmd;
  sts_t sts;

  stf_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .vertices_valid (vertices_valid),
    .vertices_stall (vertices_stall),
    .sts            (sts),
    .cmd            (cmd)
  );

  stf_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .vertices   (vertices),
    .cmd        (cmd),
    .sts        (sts),
    .span_valid (span_valid),
    .span_stall (span_stall),
    .span       (span)
  );

endmodule

// ----- rtl/stf_ctrl.sv -----
// Sequencer for the triangle filler: split point, then per-row edge evaluations.
module stf_ctrl import stf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic vertices_valid,
  output logic vertices_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_WB   = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t state, state_next;
  op_t    op, op_next;

  assign vertices_stall = (state != S_IDLE);

  always_comb begin
    state_next = state;
    op_next    = op;
    cmd        = '0;
    cmd.op     = op;
    unique case (state)
      S_IDLE: begin
        if (vertices_valid) begin
          cmd.load_tri = 1'b1;
          op_next      = OP_XS;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        if (sts.flat_all && op == OP_XS) begin
          state_next = S_EMIT;
        end else begin
          cmd.mul_go = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_WB;
      end
      S_WB: begin
        cmd.store_res = 1'b1;
        unique case (op)
          OP_XS: begin
            op_next    = OP_FROM;
            state_next = S_MUL;
          end
          OP_FROM: begin
            op_next    = OP_TO;
            state_next = S_MUL;
          end
          OP_TO: state_next = S_EMIT;
          default: state_next = S_IDLE;
        endcase
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          if (sts.last_row) begin
            state_next = S_IDLE;
          end else begin
            cmd.next_row = 1'b1;
            op_next      = OP_FROM;
            state_next   = S_MUL;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      op    <= OP_XS;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

endmodule

// ----- rtl/stf_datapath.sv -----
// Vertex sort, edge interpolation with a shared restoring divider, span output register.
module stf_datapath import stf_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  logic      clk,
  input  logic      rst,
  input  vertices_t vertices,
  input  cmd_t      cmd,
  output sts_t      sts,
  output logic      span_valid,
  input  logic      span_stall,
  output span_t     span
);

  localparam int CB = COORD_BITS;
  localparam int ND = 2 * COORD_BITS;
  localparam int CW = $clog2(ND + 1);

  // sort network
  logic [CB-1:0] s1x, s1y, s2x, s2y, s3x, s3y, tx, ty;

  always_comb begin
    s1x = vertices.vertex_a_x[CB-1:0];
    s1y = vertices.vertex_a_y[CB-1:0];
    s2x = vertices.vertex_b_x[CB-1:0];
    s2y = vertices.vertex_b_y[CB-1:0];
    s3x = vertices.vertex_c_x[CB-1:0];
    s3y = vertices.vertex_c_y[CB-1:0];
    tx  = '0;
    ty  = '0;
    if (s1y > s2y) begin
      tx = s1x; ty = s1y; s1x = s2x; s1y = s2y; s2x = tx; s2y = ty;
    end
    if (s1y > s3y) begin
      tx = s1x; ty = s1y; s1x = s3x; s1y = s3y; s3x = tx; s3y = ty;
    end
    if (s2y > s3y) begin
      tx = s2x; ty = s2y; s2x = s3x; s2y = s3y; s3x = tx; s3y = ty;
    end
  end

  logic [CB-1:0] xt, yt, xm, ym, xb, yb, xs, row, from_x, to_x;
  logic          flat_all, flat_top;

  always_ff @(posedge clk) begin
    if (cmd.load_tri) begin
      xt       <= s1x;
      yt       <= s1y;
      xm       <= s2x;
      ym       <= s2y;
      xb       <= s3x;
      yb       <= s3y;
      row      <= s1y;
      flat_all <= (s1y == s3y);
      flat_top <= (s1y == s2y);
    end else if (cmd.next_row) begin
      row <= row + 1'b1;
    end
  end

  // edge operand select
  logic          lower;
  logic [CB-1:0] x0, y0, x1, y1, rr;
  logic [CB:0]   dx, dxn;
  logic [CB-1:0] dx_mag, dy, den;
  logic [ND-1:0] prod;

  assign lower = (row >= ym);

  always_comb begin
    rr = row;
    case (cmd.op)
      OP_XS: begin
        x0 = xt; y0 = yt; x1 = xb; y1 = yb; rr = ym;
      end
      OP_FROM: begin
        if (lower) begin
          x0 = xs; y0 = ym; x1 = xb; y1 = yb;
        end else begin
          x0 = xt; y0 = yt; x1 = xs; y1 = ym;
        end
      end
      default: begin
        if (lower) begin
          x0 = xm; y0 = ym; x1 = xb; y1 = yb;
        end else begin
          x0 = xt; y0 = yt; x1 = xm; y1 = ym;
        end
      end
    endcase
  end

  assign dx     = {1'b0, x1} - {1'b0, x0};
  assign dxn    = -dx;
  assign dx_mag = dx[CB] ? dxn[CB-1:0] : dx[CB-1:0];
  assign dy     = rr - y0;
  assign den    = y1 - y0;
  assign prod   = dx_mag * dy;

  // restoring divider, quotient shifts into the dividend register
  logic [ND-1:0] dvd;
  logic [CB-1:0] rem, den_r, x0_r;
  logic          neg_r, zero_r;
  logic [CW-1:0] cnt;
  logic [CB:0]   rem_sh, rem_sub;
  logic          ge;
  logic [CB-1:0] quo, res;

  assign rem_sh  = {rem, dvd[ND-1]};
  assign rem_sub = rem_sh - {1'b0, den_r};
  assign ge      = (rem_sh >= {1'b0, den_r});
  assign quo     = dvd[CB-1:0];

  always_comb begin
    if (zero_r)     res = x0_r;
    else if (neg_r) res = x0_r - quo;
    else            res = x0_r + quo;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      dvd    <= prod;
      rem    <= '0;
      den_r  <= den;
      x0_r   <= x0;
      neg_r  <= dx[CB];
      zero_r <= (prod == '0);
      cnt    <= CW'(ND);
    end else if (cmd.div_step) begin
      dvd <= {dvd[ND-2:0], ge};
      rem <= ge ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store_res) begin
      case (cmd.op)
        OP_XS:   xs     <= res;
        OP_FROM: from_x <= res;
        default: to_x   <= res;
      endcase
    end
  end

  // flat triangle extent
  logic [CB-1:0] mn, mx;

  always_comb begin
    mn = xt;
    mx = xt;
    if (xm < mn) mn = xm;
    if (xb < mn) mn = xb;
    if (xm > mx) mx = xm;
    if (xb > mx) mx = xb;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (cmd.load_out) begin
      span_valid <= 1'b1;
    end else if (!span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      span.row       <= FIELD_W'(row);
      span.last_span <= (row == yb);
      if (flat_all) begin
        span.span_from_x <= FIELD_W'(mn);
        span.span_to_x   <= FIELD_W'(mx);
      end else if (flat_top) begin
        span.span_from_x <= FIELD_W'(to_x);
        span.span_to_x   <= FIELD_W'(from_x);
      end else begin
        span.span_from_x <= FIELD_W'(from_x);
        span.span_to_x   <= FIELD_W'(to_x);
      end
    end
  end

  assign sts.flat_all = flat_all;
  assign sts.div_last = (cnt == CW'(1));
  assign sts.last_row = (row == yb);
  assign sts.out_free = !span_valid || !span_stall;

endmodule

// ----- rtl/stf_checker.sv -----
// Port-level checks for the scanline triangle filler, bound to the top level.
module stf_checker import stf_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      vertices_valid,
  input logic      vertices_stall,
  input logic      span_valid,
  input logic      span_stall,
  input span_t     span
);

  // stalled span holds
  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && span_stall |=> span_valid && $stable(span))
    else $error("stalled span changed");

  // a pending non-final span means the triangle is still in work
  a_busy_mid: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span.last_span |-> vertices_stall)
    else $error("input open while triangle unfinished");

  // at a vertices transfer, any waiting span closes the previous triangle
  a_accept_after_last: assert property (@(posedge clk) disable iff (rst)
    vertices_valid && !vertices_stall && span_valid |-> span.last_span)
    else $error("triangle taken before previous one finished");

  // a triangle transfer starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    vertices_valid && !vertices_stall |=> vertices_stall)
    else $error("no work after triangle transfer");

endmodule

bind scanline_triangle_fill stf_checker u_stf_checker (.*);
